### sv/twna_pkg.sv
// ----------------------------------------------------------------------------
// twna_pkg
// Shared types and constants for the nearest-texel address unit.
// ----------------------------------------------------------------------------
package twna_pkg;

    localparam int COORD_W = 32;
    localparam int SIZE_W  = 13;
    localparam int TEXEL_W = 12;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;

    typedef enum logic [1:0] {
        WRAP_REPEAT          = 2'd0,
        WRAP_MIRRORED_REPEAT = 2'd1,
        WRAP_CLAMP_EDGE      = 2'd2,
        WRAP_CLAMP_BORDER    = 2'd3
    } wrap_mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_WRAP_MODE     = 2'd0,
        CFG_TEX_WIDTH     = 2'd1,
        CFG_TEX_HEIGHT    = 2'd2,
        CFG_TEXTURE_BOUND = 2'd3
    } cfg_index_t;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [SIZE_W-1:0]         size_t;
    typedef logic [TEXEL_W-1:0]        texel_t;

endpackage

### sv/twna_coord_if.sv
// ----------------------------------------------------------------------------
// twna_coord_if
// Request channel carrying one texture coordinate pair.
// ----------------------------------------------------------------------------
interface twna_coord_if;

    logic            valid;
    logic            ready;
    twna_pkg::coord_t u_coord;
    twna_pkg::coord_t v_coord;

    modport source (output valid, output u_coord, output v_coord, input ready);
    modport sink   (input valid, input u_coord, input v_coord, output ready);

endinterface

### sv/twna_texel_if.sv
// ----------------------------------------------------------------------------
// twna_texel_if
// Result channel carrying the selected texel address and status flags.
// ----------------------------------------------------------------------------
interface twna_texel_if;

    logic             valid;
    logic             ready;
    twna_pkg::texel_t texel_x;
    twna_pkg::texel_t texel_y;
    logic             use_border;
    logic             no_texture;

    modport source (
        output valid, output texel_x, output texel_y,
        output use_border, output no_texture, input ready
    );
    modport sink (
        input valid, input texel_x, input texel_y,
        input use_border, input no_texture, output ready
    );

endinterface

### sv/twna_wrap.sv
// ----------------------------------------------------------------------------
// twna_wrap
// Applies the wrap mode to one fixed point coordinate, giving [0, 1].
// ----------------------------------------------------------------------------
module twna_wrap #(
    parameter int FRAC_BITS = 16
) (
    input  twna_pkg::coord_t     raw,
    input  twna_pkg::wrap_mode_t mode,
    output logic [FRAC_BITS:0]   wrapped,
    output logic                 outside
);

    localparam logic [FRAC_BITS:0] ONE_FX = (FRAC_BITS+1)'(1) << FRAC_BITS;
    localparam twna_pkg::coord_t ONE_S = twna_pkg::coord_t'(1) <<< FRAC_BITS;

    logic [FRAC_BITS:0] frac;
    logic               below;
    logic               above;

    assign frac  = {1'b0, raw[FRAC_BITS-1:0]};
    assign below = raw < 0;
    assign above = raw > ONE_S;

    always_comb
    begin
        wrapped = frac;
        outside = 1'b0;
        case (mode)
            twna_pkg::WRAP_REPEAT:
            begin
                wrapped = frac;
            end
            twna_pkg::WRAP_MIRRORED_REPEAT:
            begin
                // odd tile by floor parity: the integer lsb of two's complement
                wrapped = raw[FRAC_BITS] ? (ONE_FX - frac) : frac;
            end
            twna_pkg::WRAP_CLAMP_EDGE:
            begin
                if (below)
                    wrapped = '0;
                else if (above)
                    wrapped = ONE_FX;
                else
                    wrapped = raw[FRAC_BITS:0];
            end
            twna_pkg::WRAP_CLAMP_BORDER:
            begin
                outside = below || above;
                wrapped = outside ? '0 : raw[FRAC_BITS:0];
            end
            default:
            begin
                wrapped = frac;
            end
        endcase
    end

endmodule

### sv/twna_scale.sv
// ----------------------------------------------------------------------------
// twna_scale
// Scales a wrapped coordinate by (size - 1) and truncates to a texel index.
// ----------------------------------------------------------------------------
module twna_scale #(
    parameter int FRAC_BITS = 16
) (
    input  logic [FRAC_BITS:0] coord,
    input  twna_pkg::size_t    size,
    output twna_pkg::texel_t   texel
);

    localparam int SW    = twna_pkg::SIZE_W;
    localparam int PROD_W = FRAC_BITS + 1 + SW;

    twna_pkg::size_t   size_m1;
    logic [PROD_W-1:0] prod;
    logic [SW:0]       quot;
    twna_pkg::size_t   index;

    assign size_m1 = size - SW'(1);
    assign prod    = PROD_W'(coord) * PROD_W'(size_m1);
    assign quot    = prod[FRAC_BITS+SW:FRAC_BITS];

    always_comb
    begin
        if (quot > {1'b0, size_m1})
            index = size_m1;
        else
            index = quot[SW-1:0];
    end

    assign texel = index[twna_pkg::TEXEL_W-1:0];

endmodule

### sv/texture_wrap_nearest_address.sv
// ----------------------------------------------------------------------------
// texture_wrap_nearest_address
// Nearest-texel address unit: wrap mode, scale to texture size, v flip.
// ----------------------------------------------------------------------------
// Takes (u, v) pairs in signed fixed point and returns the nearest texel
// column and row, held first in the input register, then in the result
// register. Throughput is one request per clock while the consumer keeps up;
// the result register frees the input side whenever the consumer takes a
// result or the result slot is empty. The critical path is the wrap select
// followed by a (FRAC_BITS+1) x 13 bit multiply per axis. Configuration
// writes apply at once and are expected only while idle. The unit keeps no
// state but the configuration, input and result registers; needs no warm-up.
module texture_wrap_nearest_address #(
    parameter int MAX_SIZE  = 4096,
    parameter int FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [twna_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [twna_pkg::CFG_DATA_W-1:0]     cfg_data,
    twna_coord_if.sink                          coord,
    twna_texel_if.source                        texel
);

    localparam logic [FRAC_BITS:0] ONE_FX = (FRAC_BITS+1)'(1) << FRAC_BITS;
    localparam int SW = twna_pkg::SIZE_W;

    // configuration
    twna_pkg::wrap_mode_t wrap_mode_reg;
    twna_pkg::size_t      tex_width_reg;
    twna_pkg::size_t      tex_height_reg;
    logic                 texture_bound_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_mode_reg     <= twna_pkg::WRAP_REPEAT;
            tex_width_reg     <= SW'(1);
            tex_height_reg    <= SW'(1);
            texture_bound_reg <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            case (twna_pkg::cfg_index_t'(cfg_index))
                twna_pkg::CFG_WRAP_MODE:
                    wrap_mode_reg <= twna_pkg::wrap_mode_t'(cfg_data[1:0]);
                twna_pkg::CFG_TEX_WIDTH:
                    tex_width_reg <= cfg_data[SW-1:0];
                twna_pkg::CFG_TEX_HEIGHT:
                    tex_height_reg <= cfg_data[SW-1:0];
                twna_pkg::CFG_TEXTURE_BOUND:
                    texture_bound_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // effective sizes: zero reads as one, above MAX_SIZE saturates
    twna_pkg::size_t w_eff;
    twna_pkg::size_t h_eff;

    always_comb
    begin
        if (tex_width_reg == '0)
            w_eff = SW'(1);
        else if (32'(tex_width_reg) > 32'(MAX_SIZE))
            w_eff = SW'(MAX_SIZE);
        else
            w_eff = tex_width_reg;

        if (tex_height_reg == '0)
            h_eff = SW'(1);
        else if (32'(tex_height_reg) > 32'(MAX_SIZE))
            h_eff = SW'(MAX_SIZE);
        else
            h_eff = tex_height_reg;
    end

    // handshake
    logic in_valid_reg;
    logic out_valid_reg;
    logic advance;
    logic take_in;

    assign advance     = !out_valid_reg || texel.ready;
    assign coord.ready = !in_valid_reg || advance;
    assign take_in     = coord.valid && coord.ready;

    // input register
    twna_pkg::coord_t u_reg;
    twna_pkg::coord_t v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (coord.ready)
            in_valid_reg <= coord.valid;
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            u_reg <= coord.u_coord;
            v_reg <= coord.v_coord;
        end
    end

    // address datapath
    logic [FRAC_BITS:0] u_wrapped;
    logic [FRAC_BITS:0] v_wrapped;
    logic [FRAC_BITS:0] v_flipped;
    logic               u_outside;
    logic               v_outside;
    twna_pkg::texel_t   x_calc;
    twna_pkg::texel_t   y_calc;

    twna_wrap #(.FRAC_BITS(FRAC_BITS)) u_wrap_u (
        .raw     (u_reg),
        .mode    (wrap_mode_reg),
        .wrapped (u_wrapped),
        .outside (u_outside)
    );

    twna_wrap #(.FRAC_BITS(FRAC_BITS)) u_wrap_v (
        .raw     (v_reg),
        .mode    (wrap_mode_reg),
        .wrapped (v_wrapped),
        .outside (v_outside)
    );

    // rows count from the top, so v is flipped
    assign v_flipped = ONE_FX - v_wrapped;

    twna_scale #(.FRAC_BITS(FRAC_BITS)) u_scale_x (
        .coord (u_wrapped),
        .size  (w_eff),
        .texel (x_calc)
    );

    twna_scale #(.FRAC_BITS(FRAC_BITS)) u_scale_y (
        .coord (v_flipped),
        .size  (h_eff),
        .texel (y_calc)
    );

    twna_pkg::texel_t texel_x_next;
    twna_pkg::texel_t texel_y_next;
    logic             use_border_next;
    logic             no_texture_next;

    always_comb
    begin
        texel_x_next    = '0;
        texel_y_next    = '0;
        use_border_next = 1'b0;
        no_texture_next = 1'b0;
        if (!texture_bound_reg)
            no_texture_next = 1'b1;
        else if (u_outside || v_outside)
            use_border_next = 1'b1;
        else
        begin
            texel_x_next = x_calc;
            texel_y_next = y_calc;
        end
    end

    // result register
    twna_pkg::texel_t texel_x_reg;
    twna_pkg::texel_t texel_y_reg;
    logic             use_border_reg;
    logic             no_texture_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            texel_x_reg    <= texel_x_next;
            texel_y_reg    <= texel_y_next;
            use_border_reg <= use_border_next;
            no_texture_reg <= no_texture_next;
        end
    end

    assign texel.valid      = out_valid_reg;
    assign texel.texel_x    = texel_x_reg;
    assign texel.texel_y    = texel_y_reg;
    assign texel.use_border = use_border_reg;
    assign texel.no_texture = no_texture_reg;

endmodule
